// ----- design/assert_macros.svh -----
// Assertion macros included by the top-level decrypt module.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) else $error(msg);
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);
`endif

// ----- design/aesd_pkg.sv -----
// Package for the AES-128 decrypt block: widths, op codes, state type and
// the GF(2^8) helpers used by the round stages. No dependencies.
package aesd_pkg;
   localparam int BLOCK_W = 128;
   localparam int NUM_KEYS = 11;

   typedef enum logic [0:0] {
      OP_LOAD_KEY = 1'b0,
      OP_DECRYPT  = 1'b1
   } op_type;

   typedef logic [BLOCK_W-1:0] block_type;

   // Round stage sideband that travels with the state.
   typedef struct packed {
      logic      chain_enable;
      block_type chain;
   } side_type;

   function automatic logic [7:0] xtime(input logic [7:0] a);
      xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] x;
      logic [7:0] r;
      x = a;
      r = '0;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) r = r ^ x;
         x = xtime(x);
      end
      gmul = r;
   endfunction

   // Inverse S-box: inverse affine map, then multiplicative inverse (a^254).
   function automatic logic [7:0] inv_sbox(input logic [7:0] y);
      logic [7:0] x;
      logic [7:0] x2;
      logic [7:0] x4;
      logic [7:0] x8;
      logic [7:0] r;
      x = {y[6:0], y[7]} ^ {y[4:0], y[7:5]} ^ {y[1:0], y[7:2]} ^ 8'h05;
      // a^254 = a^2 * a^4 * a^8 * a^16 * a^32 * a^64 * a^128
      x2 = gmul(x, x);
      r  = x2;
      x4 = gmul(x2, x2);
      r  = gmul(r, x4);
      x8 = gmul(x4, x4);
      r  = gmul(r, x8);
      for (int i = 0; i < 4; i++) begin
         x8 = gmul(x8, x8);
         r  = gmul(r, x8);
      end
      inv_sbox = r;
   endfunction

   function automatic logic [7:0] get_byte(input block_type s, input int i);
      get_byte = s[BLOCK_W-1-8*i -: 8];
   endfunction

   function automatic block_type inv_shift_sub(input block_type s);
      block_type t;
      t = '0;
      for (int r = 0; r < 4; r++)
         for (int c = 0; c < 4; c++)
            t[BLOCK_W-1-8*(r+4*((c+r)%4)) -: 8] = inv_sbox(get_byte(s, r+4*c));
      inv_shift_sub = t;
   endfunction

   function automatic block_type inv_mix(input block_type s);
      block_type t;
      logic [7:0] a0, a1, a2, a3;
      for (int c = 0; c < 4; c++) begin
         a0 = get_byte(s, 4*c);
         a1 = get_byte(s, 4*c+1);
         a2 = get_byte(s, 4*c+2);
         a3 = get_byte(s, 4*c+3);
         t[BLOCK_W-1-8*(4*c) -: 8] =
            gmul(a0, 8'h0e) ^ gmul(a1, 8'h0b) ^ gmul(a2, 8'h0d) ^ gmul(a3, 8'h09);
         t[BLOCK_W-1-8*(4*c+1) -: 8] =
            gmul(a0, 8'h09) ^ gmul(a1, 8'h0e) ^ gmul(a2, 8'h0b) ^ gmul(a3, 8'h0d);
         t[BLOCK_W-1-8*(4*c+2) -: 8] =
            gmul(a0, 8'h0d) ^ gmul(a1, 8'h09) ^ gmul(a2, 8'h0e) ^ gmul(a3, 8'h0b);
         t[BLOCK_W-1-8*(4*c+3) -: 8] =
            gmul(a0, 8'h0b) ^ gmul(a1, 8'h0d) ^ gmul(a2, 8'h09) ^ gmul(a3, 8'h0e);
      end
      inv_mix = t;
   endfunction
endpackage

// ----- design/aesd_req_if.sv -----
// Request channel interface for the AES-128 decrypt block.
// Depends on nothing.
interface aesd_req_if;
   logic        valid;
   logic        ready;
   logic        op;
   logic [3:0]  key_round;
   logic [63:0] data_hi;
   logic [63:0] data_lo;
   logic [63:0] chain_hi;
   logic [63:0] chain_lo;
   logic        chain_enable;
   modport source (output valid, op, key_round, data_hi, data_lo, chain_hi, chain_lo,
                   chain_enable, input ready);
   modport sink (input valid, op, key_round, data_hi, data_lo, chain_hi, chain_lo,
                 chain_enable, output ready);
endinterface

// ----- design/aesd_rsp_if.sv -----
// Response channel interface for the AES-128 decrypt block.
// Depends on nothing.
interface aesd_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] plain_hi;
   logic [63:0] plain_lo;
   modport source (output valid, plain_hi, plain_lo, input ready);
   modport sink (input valid, plain_hi, plain_lo, output ready);
endinterface

// ----- design/aesd_round.sv -----
// One inverse round stage: InvShiftRows, InvSubBytes, AddRoundKey, optional
// InvMixColumns, then a register. Depends on aesd_pkg.
module aesd_round #(
   parameter bit LAST = 1'b0
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic                in_valid,
   input  aesd_pkg::block_type in_state,
   input  aesd_pkg::side_type  in_side,
   input  aesd_pkg::block_type round_key,
   output logic                out_valid,
   output aesd_pkg::block_type out_state,
   output aesd_pkg::side_type  out_side
);
   import aesd_pkg::*;

   logic      valid_ff;
   block_type state_ff;
   block_type state_in;
   side_type  side_ff;
   block_type added;

   always_comb begin
      added = inv_shift_sub(in_state) ^ round_key;
      state_in = LAST ? added : inv_mix(added);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
      if (advance) begin
         state_ff <= state_in;
         side_ff  <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_state = state_ff;
   assign out_side  = side_ff;
endmodule

// ----- design/aes128_block_decrypt.sv -----
// Top level of the AES-128 decrypt block; instantiates aesd_round.
// Depends on aesd_pkg, aesd_req_if, aesd_rsp_if and assert_macros.svh.
//
// AES-128 inverse cipher, one block accepted per cycle while not stalled.
// Round keys sit in flip-flops and are loaded by op 0 items (index above
// 10 is dropped); all eleven must be loaded before decrypting. A decrypt
// item passes an input key-add register and ten round registers, one round
// per stage, before its result reaches the output. A whole-pipe stall holds
// everything while the output is full and not taken. A key-load item waits
// at the input until no decrypt is in flight.
module aes128_block_decrypt (
   input logic clock,
   input logic reset,
   aesd_req_if.sink   req,
   aesd_rsp_if.source rsp
);
   import aesd_pkg::*;
`include "assert_macros.svh"

   localparam int NSTG = NUM_KEYS - 1;

   block_type rk_ff [NUM_KEYS];
   logic      advance;
   logic      v [NSTG+1];
   block_type st [NSTG+1];
   side_type  sd [NSTG+1];
   logic      v0_ff;
   block_type s0_ff;
   side_type  d0_ff;
   logic      acc;
   logic      busy;

   // Stall the whole pipe only when the output holds an item not taken.
   assign advance = !v[NSTG] || rsp.ready;

   always_comb begin
      busy = 1'b0;
      for (int i = 0; i <= NSTG; i++) busy = busy | v[i];
   end

   // Hold key loads until every decrypt in flight has left.
   assign req.ready = advance && (req.op == OP_DECRYPT || !busy);
   assign acc = req.valid && req.ready;

   always_ff @(posedge clock) begin
      if (acc && req.op == OP_LOAD_KEY && req.key_round < 4'(NUM_KEYS)) begin
         rk_ff[req.key_round] <= {req.data_hi, req.data_lo};
      end
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (advance) begin
         v0_ff <= acc && req.op == OP_DECRYPT;
      end
      if (advance) begin
         s0_ff <= {req.data_hi, req.data_lo} ^ rk_ff[NUM_KEYS-1];
         d0_ff <= '{chain_enable: req.chain_enable, chain: {req.chain_hi, req.chain_lo}};
      end
   end

   assign v[0]  = v0_ff;
   assign st[0] = s0_ff;
   assign sd[0] = d0_ff;

   for (genvar g = 0; g < NSTG; g++) begin : g_rnd
      aesd_round #(.LAST(g == NSTG-1)) u_round (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (v[g]),
         .in_state  (st[g]),
         .in_side   (sd[g]),
         .round_key (rk_ff[NSTG-1-g]),
         .out_valid (v[g+1]),
         .out_state (st[g+1]),
         .out_side  (sd[g+1])
      );
   end

   assign rsp.valid = v[NSTG];
   assign {rsp.plain_hi, rsp.plain_lo} =
      st[NSTG] ^ (sd[NSTG].chain_enable ? sd[NSTG].chain : '0);

   `ASSERT_IMPLY(a_ready_when_empty, clock, reset, !rsp.valid && req.op == OP_DECRYPT,
                 req.ready, "input stalled with empty output")
   `ASSERT_NEXT(a_hold_on_stall, clock, reset, rsp.valid && !rsp.ready,
                rsp.valid && $stable(rsp.plain_hi), "result dropped during stall")
   `ASSERT_NEXT(a_key_no_result, clock, reset,
                req.valid && req.ready && req.op == OP_LOAD_KEY, !v[0],
                "key load entered the pipe")
endmodule

// ----- bench/tb_top.sv -----
// Testbench for aes128_block_decrypt: loads round keys, decrypts blocks with
// and without chaining, and checks each plaintext against an inline model.
// Depends on aes128_block_decrypt, aesd_pkg, aesd_req_if and aesd_rsp_if.
`timescale 1ns / 100ps

module tb_top;
   import aesd_pkg::*;

   typedef struct {
      op_type      op;
      logic [3:0]  key_round;
      logic [63:0] data_hi;
      logic [63:0] data_lo;
      logic [63:0] chain_hi;
      logic [63:0] chain_lo;
      logic        chain_enable;
   } req_item_type;

   typedef struct {
      logic [63:0] hi;
      logic [63:0] lo;
   } plain_type;

   localparam int CYCLE_LIMIT = 400000;
   localparam int PIPE_DRAIN  = 16;

   logic clock;
   logic reset;
   aesd_req_if req_ch ();
   aesd_rsp_if rsp_ch ();

   aes128_block_decrypt u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch.sink),
      .rsp   (rsp_ch.source)
   );

   logic [127:0] round_keys [NUM_KEYS];
   logic [7:0]   inv_sbox_tab [256];
   plain_type    plain_queue [$];
   int           error_count;
   int           cycle_count;
   int           idle_pct;
   int           stall_pct;

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   // GF(2^8) multiply, polynomial 0x11b
   function automatic logic [7:0] fmul(input logic [7:0] a, input logic [7:0] b);
      logic [8:0] x;
      logic [7:0] r;
      x = {1'b0, a};
      r = 8'h00;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) r ^= x[7:0];
         x = x << 1;
         if (x[8]) x ^= 9'h11b;
      end
      return r;
   endfunction

   function automatic logic [7:0] rotl(input logic [7:0] v, input int n);
      return (v << n) | (v >> (8 - n));
   endfunction

   // Build the inverse S-box by inverting the forward one.
   task automatic build_inv_sbox();
      logic [7:0] inv;
      logic [7:0] s;
      for (int x = 0; x < 256; x++) begin
         inv = 8'h00;
         for (int y = 1; y < 256; y++)
            if (fmul(x[7:0], y[7:0]) == 8'h01) inv = y[7:0];
         s = inv ^ rotl(inv, 1) ^ rotl(inv, 2) ^ rotl(inv, 3) ^ rotl(inv, 4) ^ 8'h63;
         inv_sbox_tab[s] = x[7:0];
      end
   endtask

   function automatic logic [127:0] decipher_block(input logic [127:0] ct);
      logic [7:0] st [16];
      logic [7:0] tmp [16];
      logic [7:0] a0, a1, a2, a3;
      logic [127:0] res;
      for (int i = 0; i < 16; i++) st[i] = ct[127-8*i -: 8] ^ round_keys[10][127-8*i -: 8];
      for (int rnd = 9; rnd >= 0; rnd--) begin
         for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
               tmp[r + 4*((c + r) % 4)] = inv_sbox_tab[st[r + 4*c]];
         for (int i = 0; i < 16; i++) st[i] = tmp[i] ^ round_keys[rnd][127-8*i -: 8];
         if (rnd > 0) begin
            for (int c = 0; c < 4; c++) begin
               a0 = st[4*c]; a1 = st[4*c+1]; a2 = st[4*c+2]; a3 = st[4*c+3];
               st[4*c]   = fmul(a0, 8'h0e) ^ fmul(a1, 8'h0b) ^ fmul(a2, 8'h0d) ^ fmul(a3, 8'h09);
               st[4*c+1] = fmul(a0, 8'h09) ^ fmul(a1, 8'h0e) ^ fmul(a2, 8'h0b) ^ fmul(a3, 8'h0d);
               st[4*c+2] = fmul(a0, 8'h0d) ^ fmul(a1, 8'h09) ^ fmul(a2, 8'h0e) ^ fmul(a3, 8'h0b);
               st[4*c+3] = fmul(a0, 8'h0b) ^ fmul(a1, 8'h0d) ^ fmul(a2, 8'h09) ^ fmul(a3, 8'h0e);
            end
         end
      end
      for (int i = 0; i < 16; i++) res[127-8*i -: 8] = st[i];
      return res;
   endfunction

   task automatic note_accepted(input req_item_type it);
      plain_type p;
      logic [127:0] pt;
      if (it.op == OP_LOAD_KEY) begin
         if (it.key_round < NUM_KEYS) round_keys[it.key_round] = {it.data_hi, it.data_lo};
      end else begin
         pt = decipher_block({it.data_hi, it.data_lo});
         if (it.chain_enable) pt ^= {it.chain_hi, it.chain_lo};
         p.hi = pt[127:64];
         p.lo = pt[63:0];
         plain_queue.push_back(p);
      end
   endtask

   task automatic send_item(input req_item_type it);
      while ($urandom_range(99) < idle_pct) begin
         req_ch.valid = 1'b0;
         @(negedge clock);
      end
      req_ch.op           = it.op;
      req_ch.key_round    = it.key_round;
      req_ch.data_hi      = it.data_hi;
      req_ch.data_lo      = it.data_lo;
      req_ch.chain_hi     = it.chain_hi;
      req_ch.chain_lo     = it.chain_lo;
      req_ch.chain_enable = it.chain_enable;
      req_ch.valid        = 1'b1;
      do @(posedge clock); while (!req_ch.ready);
      note_accepted(it);
      @(negedge clock);
      req_ch.valid = 1'b0;
   endtask

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycle_count);
      error_count++;
   endtask

   always @(negedge clock)
      rsp_ch.ready <= ($urandom_range(99) >= stall_pct);

   always @(posedge clock) begin
      plain_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (plain_queue.size() == 0) begin
            report_mismatch("unexpected result", rsp_ch.plain_hi, '0);
         end else begin
            want = plain_queue.pop_front();
            if (rsp_ch.plain_hi !== want.hi) report_mismatch("plain_hi", rsp_ch.plain_hi, want.hi);
            if (rsp_ch.plain_lo !== want.lo) report_mismatch("plain_lo", rsp_ch.plain_lo, want.lo);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Hold off the sender until the pipe is empty.
   task automatic drain_pipe();
      while (plain_queue.size() != 0) @(posedge clock);
      repeat (PIPE_DRAIN) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic load_key(input int idx, input logic [63:0] hi, input logic [63:0] lo);
      req_item_type it;
      it = '{OP_LOAD_KEY, idx[3:0], hi, lo, rand64(), rand64(), 1'($urandom_range(1))};
      send_item(it);
   endtask

   task automatic decrypt(input logic [63:0] hi, input logic [63:0] lo, input logic [63:0] chi,
                          input logic [63:0] clo, input logic en);
      req_item_type it;
      it = '{OP_DECRYPT, 4'($urandom_range(15)), hi, lo, chi, clo, en};
      send_item(it);
   endtask

   task automatic load_random_keys();
      drain_pipe();
      for (int k = 0; k < NUM_KEYS; k++) load_key(k, rand64(), rand64());
   endtask

   task automatic test_extremes();
      drain_pipe();
      for (int k = 0; k < NUM_KEYS; k++) load_key(k, '0, '0);
      decrypt('0, '0, '0, '0, 1'b0);
      decrypt('1, '1, '1, '1, 1'b1);
      drain_pipe();
      for (int k = 0; k < NUM_KEYS; k++) load_key(k, '1, '1);
      decrypt('0, '1, '1, '0, 1'b0);
      decrypt('1, '0, '0, '1, 1'b1);
   endtask

   task automatic test_bad_key_index();
      load_random_keys();
      // out-of-range loads must leave the store alone
      load_key(11, '1, '1);
      load_key(15, '0, '0);
      decrypt(rand64(), rand64(), rand64(), rand64(), 1'b0);
      decrypt(rand64(), rand64(), rand64(), rand64(), 1'b1);
      decrypt(rand64(), rand64(), '1, '1, 1'b0);
   endtask

   task automatic test_random_traffic(input int n_items);
      for (int i = 0; i < n_items; i++) begin
         if ($urandom_range(99) < 3) begin
            load_random_keys();
            if ($urandom_range(1) != 0) begin
               load_key(int'($urandom_range(15, 11)), rand64(), rand64());
            end
         end else if ($urandom_range(99) < 2) begin
            // reload one key while decrypts are still in flight
            load_key(int'($urandom_range(10)), rand64(), rand64());
         end else begin
            decrypt(rand64(), rand64(), rand64(), rand64(), 1'($urandom_range(1)));
         end
      end
   endtask

   initial begin
      error_count     = 0;
      cycle_count     = 0;
      idle_pct        = 0;
      stall_pct       = 0;
      reset           = 1'b1;
      req_ch.valid    = 1'b0;
      req_ch.op       = OP_LOAD_KEY;
      req_ch.key_round = '0;
      req_ch.data_hi  = '0;
      req_ch.data_lo  = '0;
      req_ch.chain_hi = '0;
      req_ch.chain_lo = '0;
      req_ch.chain_enable = 1'b0;
      rsp_ch.ready    = 1'b1;
      build_inv_sbox();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_extremes();
      test_bad_key_index();
      load_random_keys();
      test_random_traffic(110);
      idle_pct = 61;
      test_random_traffic(110);
      idle_pct  = 0;
      stall_pct = 61;
      test_random_traffic(110);
      idle_pct  = 10;
      stall_pct = 10;
      test_random_traffic(110);

      while (plain_queue.size() != 0) @(posedge clock);
      repeat (PIPE_DRAIN) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule
